// ----- rtl/apd_pkg.sv -----
package apd_pkg;

	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned DELTA_W     = 8;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [SAMPLE_W-1:0] MID_LEVEL_RESET = 16'd512;

	// history count saturates once two samples are held
	localparam logic [1:0] HIST_FULL = 2'd2;

	typedef enum logic [1:0] {
		KIND_NEW_HIGH = 2'd0,
		KIND_NEW_LOW  = 2'd1,
		KIND_REV_HIGH = 2'd2,
		KIND_REV_LOW  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [TIME_W-1:0]   peak_time;
		logic [SAMPLE_W-1:0] peak_value;
	} event_t;

	// classifier state seen from outside the front end
	typedef struct packed {
		logic seeking_low;
		logic high_seen;
		logic low_seen;
	} front_status_t;

	// request handed from front end to queue
	typedef struct packed {
		logic   push;
		event_t evt;
	} push_req_t;

	// queue head handed to back end
	typedef struct packed {
		logic   valid;
		logic   full;
		event_t evt;
	} queue_head_t;

endpackage

// ----- rtl/alternating_peak_detector.sv -----
// Alternating peak/valley detector. Each input request carries a time delta
// and a 16-bit sample; the block judges the previous sample against its two
// neighbors and emits at most one event (new high, new low, revised high,
// revised low) with the running time and the peak value. One sample is
// accepted every clock cycle while the event queue has room: the classifier
// does its compares combinationally and updates its peak state at the edge
// that accepts the sample. An event is written into the event queue at the
// edge that accepts its sample and moves on into the output register once
// the output side is free. in_ready drops only while the event queue is
// full, which happens only when the output side stalls. mid_level (reset
// 512) is written through the cfg channel, which is always ready; write it
// only while no sample is in flight. QUEUE_DEPTH must be 2 or more.
module alternating_peak_detector #(
	parameter int unsigned QUEUE_DEPTH = apd_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [apd_pkg::SAMPLE_W-1:0]  cfg_data,
	// sample channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [apd_pkg::DELTA_W-1:0]   time_delta,
	input  logic [apd_pkg::SAMPLE_W-1:0]  sample_value,
	// event channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    event_kind,
	output logic [apd_pkg::TIME_W-1:0]    peak_time,
	output logic [apd_pkg::SAMPLE_W-1:0]  peak_value
);

	apd_pkg::push_req_t     push_req;
	apd_pkg::queue_head_t   head;
	apd_pkg::front_status_t status;
	logic                   accept;
	logic                   pop;

	// register write never stalls
	assign cfg_ready = 1'b1;

	// front end only waits on queue space, never on the output side directly
	assign in_ready = !head.full;
	assign accept   = in_valid && in_ready;

	// front end: holds sample history and peak state, classifies each request
	apd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.time_delta   (time_delta),
		.sample_value (sample_value),
		.push_req     (push_req),
		.status       (status)
	);

	// short event queue so front and back stall independently
	apd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_req (push_req),
		.pop      (pop),
		.head     (head)
	);

	// back end: output register toward the consumer
	apd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.event_kind (event_kind),
		.peak_time  (peak_time),
		.peak_value (peak_value)
	);

	// a new high always switches the search to lows
	a_new_high_flips : assert property (@(posedge clk) disable iff (!arst_n)
		push_req.push && (push_req.evt.kind == apd_pkg::KIND_NEW_HIGH)
		|=> status.seeking_low)
		else $error("new high did not switch to seeking low");

	// a new low always switches the search to highs
	a_new_low_flips : assert property (@(posedge clk) disable iff (!arst_n)
		push_req.push && (push_req.evt.kind == apd_pkg::KIND_NEW_LOW)
		|=> !status.seeking_low)
		else $error("new low did not switch to seeking high");

	// a revision needs an earlier peak of the same kind
	a_rev_needs_peak : assert property (@(posedge clk) disable iff (!arst_n)
		push_req.push && ((push_req.evt.kind == apd_pkg::KIND_REV_HIGH && !status.high_seen)
		|| (push_req.evt.kind == apd_pkg::KIND_REV_LOW && !status.low_seen)) |-> 1'b0)
		else $error("revision issued with no earlier peak");

	// no event is dropped at the queue
	a_no_push_full : assert property (@(posedge clk) disable iff (!arst_n)
		push_req.push |-> !head.full)
		else $error("event pushed into a full queue");

	// output only turns valid after an event sat in the queue
	a_out_from_queue : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(head.valid))
		else $error("output valid without a queued event");

endmodule

// ----- rtl/apd_front.sv -----
module apd_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [apd_pkg::SAMPLE_W-1:0]        cfg_data,
	input  logic                                accept,
	input  logic [apd_pkg::DELTA_W-1:0]         time_delta,
	input  logic [apd_pkg::SAMPLE_W-1:0]        sample_value,
	output apd_pkg::push_req_t                  push_req,
	output apd_pkg::front_status_t              status
);

	logic [apd_pkg::SAMPLE_W-1:0] mid_level_q;
	logic [apd_pkg::SAMPLE_W-1:0] prev_q;
	logic [apd_pkg::SAMPLE_W-1:0] prev_prev_q;
	logic [1:0]                   hist_q;
	logic [apd_pkg::TIME_W-1:0]   run_time_q;
	logic                         seeking_low_q;
	logic [apd_pkg::SAMPLE_W-1:0] last_high_q;
	logic [apd_pkg::SAMPLE_W-1:0] last_low_q;
	logic                         high_seen_q;
	logic                         low_seen_q;

	logic          full;
	logic          new_high;
	logic          new_low;
	logic          rev_high;
	logic          rev_low;
	logic          hit;
	apd_pkg::kind_t kind;

	assign full = (hist_q == apd_pkg::HIST_FULL);

	assign new_high = full && !seeking_low_q && (prev_q > mid_level_q)
		&& (prev_q > prev_prev_q) && (prev_q >= sample_value);
	assign new_low  = full && seeking_low_q && (prev_q < mid_level_q)
		&& (prev_q <= prev_prev_q) && (prev_q < sample_value);
	assign rev_high = seeking_low_q && high_seen_q && (prev_q > last_high_q);
	assign rev_low  = !seeking_low_q && low_seen_q && (prev_q < last_low_q);
	assign hit      = new_high || new_low || rev_high || rev_low;

	// priority follows the check order
	always_comb begin
		if (new_high) begin
			kind = apd_pkg::KIND_NEW_HIGH;
		end else if (new_low) begin
			kind = apd_pkg::KIND_NEW_LOW;
		end else if (rev_high) begin
			kind = apd_pkg::KIND_REV_HIGH;
		end else begin
			kind = apd_pkg::KIND_REV_LOW;
		end
	end

	assign push_req.push           = accept && hit;
	assign push_req.evt.kind       = kind;
	assign push_req.evt.peak_time  = run_time_q;
	assign push_req.evt.peak_value = prev_q;

	assign status.seeking_low = seeking_low_q;
	assign status.high_seen   = high_seen_q;
	assign status.low_seen    = low_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_level_q <= apd_pkg::MID_LEVEL_RESET;
		end else if (cfg_valid) begin
			mid_level_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q        <= '0;
			prev_prev_q   <= '0;
			hist_q        <= '0;
			run_time_q    <= '0;
			seeking_low_q <= 1'b1;
			last_high_q   <= '0;
			last_low_q    <= '0;
			high_seen_q   <= 1'b0;
			low_seen_q    <= 1'b0;
		end else if (accept) begin
			if (new_high) begin
				last_high_q   <= prev_q;
				high_seen_q   <= 1'b1;
				seeking_low_q <= 1'b1;
			end else if (new_low) begin
				last_low_q    <= prev_q;
				low_seen_q    <= 1'b1;
				seeking_low_q <= 1'b0;
			end else if (rev_high) begin
				last_high_q <= prev_q;
			end else if (rev_low) begin
				last_low_q <= prev_q;
			end
			run_time_q  <= run_time_q + apd_pkg::TIME_W'(time_delta);
			prev_prev_q <= prev_q;
			prev_q      <= sample_value;
			if (!full) begin
				hist_q <= hist_q + 2'd1;
			end
		end
	end

endmodule

// ----- rtl/apd_queue.sv -----
module apd_queue #(
	parameter int unsigned DEPTH = apd_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  apd_pkg::push_req_t   push_req,
	input  logic                 pop,
	output apd_pkg::queue_head_t head
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	apd_pkg::event_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + PTR_W'(1);
		end
		return nxt;
	endfunction

	assign head.valid = (count_q != '0);
	assign head.full  = (count_q == CNT_W'(DEPTH));
	assign head.evt   = mem_q[rd_ptr_q];

	assign do_push = push_req.push && !head.full;
	assign do_pop  = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_req.evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/apd_back.sv -----
module apd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  apd_pkg::queue_head_t          head,
	output logic                          pop,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [1:0]                    event_kind,
	output logic [apd_pkg::TIME_W-1:0]    peak_time,
	output logic [apd_pkg::SAMPLE_W-1:0]  peak_value
);

	logic            out_valid_q;
	apd_pkg::event_t evt_q;

	// refill the output register when it is empty or being taken
	assign pop = head.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			evt_q <= head.evt;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = evt_q.kind;
	assign peak_time  = evt_q.peak_time;
	assign peak_value = evt_q.peak_value;

endmodule
